>>> src/tcc_pkg.sv
// Package for the t-way coverage counter: field widths, map geometry,
// register indexes and the control struct between sequencer and enumerator.
// No dependencies.
package tcc_pkg;

  localparam int unsigned NUM_VAR_W  = 5;
  localparam int unsigned STRENGTH_W = 3;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned NEW_W   = 11;
  localparam int unsigned COUNT_W = 15;

  // Covered map: one epoch tag per tuple entry
  localparam int unsigned MAP_DEPTH = 32768;
  localparam int unsigned MAP_AW    = 15;
  localparam int unsigned EPOCH_W   = 4;

  localparam logic [NUM_VAR_W-1:0]  NUM_VAR_RST  = 5'd16;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_VARIABLES        = 1'b0,
    REG_INTERACTION_STRENGTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;     // capture config bits, restart at the first combination
    logic advance;  // step to the next combination
  } gen_ctrl_t;

endpackage

>>> src/tcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tcc_comb_gen.sv
// Combination enumerator: walks the t-subsets of n variables in lexicographic
// order and forms the map address rank * 2^t + value tuple. Uses tcc_pkg.
module tcc_comb_gen #(
  parameter int unsigned MAX_VARIABLES = 16,
  parameter int unsigned MAX_STRENGTH  = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tcc_pkg::gen_ctrl_t                      ctrl_i,
  input  logic [MAX_VARIABLES-1:0]                config_bits_i,
  input  logic [$clog2(MAX_VARIABLES+1)-1:0]      n_i,
  input  logic [tcc_pkg::STRENGTH_W-1:0]          t_i,
  output logic [tcc_pkg::MAP_AW-1:0]              addr_o,
  output logic                                    last_o,
  output logic [tcc_pkg::COUNT_W-1:0]             rank_o
);
  import tcc_pkg::*;

  localparam int unsigned SEL_W = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
  localparam int unsigned CMP_W = $clog2(MAX_VARIABLES + MAX_STRENGTH + 1);
  localparam int unsigned PIV_W = (MAX_STRENGTH > 1) ? $clog2(MAX_STRENGTH) : 1;

  logic [SEL_W-1:0]         sel_q [MAX_STRENGTH];
  logic [SEL_W-1:0]         sel_d [MAX_STRENGTH];
  logic [MAX_VARIABLES-1:0] cfg_q;
  logic [COUNT_W-1:0]       rank_q;
  logic [MAX_STRENGTH-1:0]  tuple;
  logic [MAP_AW-1:0]        rank_sh;
  logic [PIV_W-1:0]         piv;
  logic                     found;
  logic [SEL_W-1:0]         piv_sel;

  always_comb begin
    tuple = '0;
    found = 1'b0;
    piv   = '0;
    for (int j = 0; j < MAX_STRENGTH; j++) begin
      if (j < int'(t_i)) begin
        tuple[j] = cfg_q[sel_q[j]];
        // rightmost position still below its ceiling n - t + j
        if (CMP_W'(sel_q[j]) < CMP_W'(n_i) + CMP_W'(j) - CMP_W'(t_i)) begin
          found = 1'b1;
          piv   = PIV_W'(j);
        end
      end
    end
  end

  assign piv_sel = sel_q[piv];

  always_comb begin
    for (int k = 0; k < MAX_STRENGTH; k++) begin
      if (ctrl_i.load) begin
        sel_d[k] = SEL_W'(k);
      end else if (ctrl_i.advance && found && k >= int'(piv)) begin
        sel_d[k] = SEL_W'(int'(piv_sel) + 1 + k - int'(piv));
      end else begin
        sel_d[k] = sel_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
      for (int k = 0; k < MAX_STRENGTH; k++) begin
        sel_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_STRENGTH; k++) begin
        sel_q[k] <= sel_d[k];
      end
      if (ctrl_i.load) begin
        rank_q <= '0;
      end else if (ctrl_i.advance) begin
        rank_q <= rank_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cfg_q <= config_bits_i;
    end
  end

  assign rank_sh = rank_q << t_i;
  assign addr_o  = rank_sh | MAP_AW'(tuple);
  assign last_o  = !found;
  assign rank_o  = rank_q;

endmodule

>>> src/t_way_coverage_counter.sv
// t-way coverage counter top level: sequencer, counters and covered map; uses tcc_pkg,
// tcc_ram and tcc_comb_gen. An item that counts does one map test-and-set per cycle over
// its C(n,t) combinations, then drains and shows its result; others go straight to the
// result. Throughput: one item at a time; busy stays high until the result is shown, and
// done_o marks the result for one cycle since the receiver cannot stall. Reset clears all
// 32768 map entries; every 15th start_new_set exhausts the epoch tags and adds a clearing pass.
module t_way_coverage_counter #(
  parameter int unsigned MAX_VARIABLES = 16,
  parameter int unsigned MAX_STRENGTH  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Command
  input  logic                               start,
  output logic                               busy,
  input  logic [MAX_VARIABLES-1:0]           config_bits_i,
  input  logic                               start_new_set_i,
  // Result
  output logic                               done_o,
  output logic [tcc_pkg::NEW_W-1:0]          new_tuples_o,
  output logic [tcc_pkg::COUNT_W-1:0]        covered_count_o,
  output logic [tcc_pkg::COUNT_W-1:0]        possible_count_o
);
  import tcc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_VARIABLES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  state_e after_clr_q, after_clr_d;

  // Configuration registers
  logic [NUM_VAR_W-1:0]  num_var_q;
  logic [STRENGTH_W-1:0] strength_q;

  // Per-item context
  logic [NW-1:0]         n_q, n_d;
  logic [STRENGTH_W-1:0] t_q, t_d;
  logic                  counting_q, counting_d;
  logic [NW-1:0]         n_eff;
  logic                  t_ok;

  // Map control
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [MAP_AW-1:0]  clr_addr_q, clr_addr_d;
  logic               p_valid_q, p_valid_d;
  logic [MAP_AW-1:0]  p_addr_q, p_addr_d;
  logic               fwd_q, fwd_d;
  logic               hit;

  // Counters
  logic [NEW_W-1:0]   fresh_q, fresh_d;
  logic [COUNT_W-1:0] running_q, running_d;

  // Result registers
  logic               done_q, done_d;
  logic [NEW_W-1:0]   new_q, new_d;
  logic [COUNT_W-1:0] cov_q, cov_d;
  logic [COUNT_W-1:0] poss_q, poss_d;
  logic [COUNT_W-1:0] poss_full;

  // RAM and enumerator hookup
  logic               ram_we;
  logic [MAP_AW-1:0]  ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [EPOCH_W-1:0] ram_rdata;
  gen_ctrl_t          gen_ctrl;
  logic [MAP_AW-1:0]  gen_addr;
  logic               gen_last;
  logic [COUNT_W-1:0] gen_rank;
  logic               accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Configuration writes land at once; software writes only while idle, a rule the block leaves to the user
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_var_q  <= NUM_VAR_RST;
      strength_q <= STRENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_VARIABLES:        num_var_q  <= cfg_wdata_i[NUM_VAR_W-1:0];
        REG_INTERACTION_STRENGTH: strength_q <= cfg_wdata_i[STRENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp n to the variables the port carries; decide whether anything counts
  always_comb begin
    if (int'(num_var_q) > int'(MAX_VARIABLES)) begin
      n_eff = NW'(MAX_VARIABLES);
    end else begin
      n_eff = NW'(num_var_q);
    end
    t_ok = (strength_q != '0) && (int'(strength_q) <= int'(MAX_STRENGTH))
        && (int'(strength_q) <= int'(n_eff));
  end

  // A tuple is covered when its tag carries the live epoch, or when the
  // previous lookup (whose write the RAM read missed) hit the same entry
  assign hit = (ram_rdata == epoch_q) || fwd_q;

  assign poss_full = gen_rank << t_q;

  always_comb begin
    state_d     = state_q;
    after_clr_d = after_clr_q;
    n_d         = n_q;
    t_d         = t_q;
    counting_d  = counting_q;
    epoch_d     = epoch_q;
    clr_addr_d  = clr_addr_q;
    p_valid_d   = 1'b0;
    p_addr_d    = p_addr_q;
    fwd_d       = 1'b0;
    fresh_d     = fresh_q;
    running_d   = running_q;
    done_d      = 1'b0;
    new_d       = new_q;
    cov_d       = cov_q;
    poss_d      = poss_q;
    ram_we      = 1'b0;
    ram_waddr   = p_addr_q;
    ram_wdata   = epoch_q;
    gen_ctrl    = '0;

    // Retire the lookup issued last cycle: mark it and count it if new
    if (p_valid_q && !hit) begin
      ram_we  = 1'b1;
      fresh_d = fresh_q + NEW_W'(1);
      if (running_q != '1) begin
        running_d = running_q + COUNT_W'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          gen_ctrl.load = 1'b1;
          n_d           = n_eff;
          t_d           = strength_q;
          counting_d    = t_ok;
          fresh_d       = '0;
          if (start_new_set_i) begin
            running_d = '0;
          end
          if (start_new_set_i && (epoch_q == '1)) begin
            // Out of fresh epoch tags: wipe the map first
            clr_addr_d  = '0;
            after_clr_d = t_ok ? ST_RUN : ST_DONE;
            state_d     = ST_CLEAR;
          end else begin
            if (start_new_set_i) begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
            state_d = t_ok ? ST_RUN : ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + MAP_AW'(1);
        if (clr_addr_q == '1) begin
          epoch_d = EPOCH_W'(1);
          state_d = after_clr_q;
        end
      end
      ST_RUN: begin
        // Issue one lookup per cycle and step the enumerator
        gen_ctrl.advance = 1'b1;
        p_valid_d        = 1'b1;
        p_addr_d         = gen_addr;
        fwd_d            = p_valid_q && (gen_addr == p_addr_q);
        if (gen_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_d  = 1'b1;
        new_d   = fresh_q;
        cov_d   = running_q;
        poss_d  = counting_q ? poss_full : '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      after_clr_q <= ST_IDLE;
      counting_q  <= 1'b0;
      epoch_q     <= '0;
      clr_addr_q  <= '0;
      p_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      fresh_q     <= '0;
      running_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      after_clr_q <= after_clr_d;
      counting_q  <= counting_d;
      epoch_q     <= epoch_d;
      clr_addr_q  <= clr_addr_d;
      p_valid_q   <= p_valid_d;
      fwd_q       <= fwd_d;
      fresh_q     <= fresh_d;
      running_q   <= running_d;
      done_q      <= done_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    t_q      <= t_d;
    p_addr_q <= p_addr_d;
    new_q    <= new_d;
    cov_q    <= cov_d;
    poss_q   <= poss_d;
  end

  tcc_comb_gen #(
    .MAX_VARIABLES (MAX_VARIABLES),
    .MAX_STRENGTH  (MAX_STRENGTH)
  ) u_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (gen_ctrl),
    .config_bits_i (config_bits_i),
    .n_i           (n_q),
    .t_i           (t_q),
    .addr_o        (gen_addr),
    .last_o        (gen_last),
    .rank_o        (gen_rank)
  );

  tcc_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (gen_addr),
    .rdata_o (ram_rdata)
  );

  assign done_o           = done_q;
  assign new_tuples_o     = new_q;
  assign covered_count_o  = cov_q;
  assign possible_count_o = poss_q;

endmodule
